/* src/c2u_pkg.sv */
// ----------------------------------------------------------------------------
// c2u_pkg: shared types and constants
// Shared types, charset and error mode codes and register addresses of the
// charset-to-UTF-8 decoder.
// ----------------------------------------------------------------------------
package c2u_pkg;

    typedef struct packed {
        logic [2:0] charset;
        logic [1:0] error_mode;
    } cfg_t;

    localparam logic [2:0] CS_UTF8    = 3'd0;
    localparam logic [2:0] CS_UTF16LE = 3'd1;
    localparam logic [2:0] CS_UTF16BE = 3'd2;
    localparam logic [2:0] CS_ASCII   = 3'd3;

    localparam logic [1:0] EM_IGNORE     = 2'd0;
    localparam logic [1:0] EM_REPLACE    = 2'd1;
    localparam logic [1:0] EM_STRICT     = 2'd2;
    localparam logic [1:0] EM_STRICT_ALT = 2'd3;

    localparam logic [1:0] ORD_NONE = 2'd0;
    localparam logic [1:0] ORD_LE   = 2'd1;
    localparam logic [1:0] ORD_BE   = 2'd2;

    localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
    localparam logic [20:0] CP_QMARK   = 21'h00003F;
    localparam logic [7:0]  ASCII_LOW  = 8'h20;
    localparam logic [7:0]  ASCII_DEL  = 8'h7F;

    localparam int APB_AW = 3;
    localparam logic REG_CHARSET = 1'b0;
    localparam logic REG_MODE    = 1'b1;

endpackage

/* src/c2u_in_if.sv */
// ----------------------------------------------------------------------------
// c2u_in_if: raw byte channel
// Valid/ready channel that carries one raw byte and its end mark.
// ----------------------------------------------------------------------------
interface c2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/c2u_out_if.sv */
// ----------------------------------------------------------------------------
// c2u_out_if: UTF-8 result channel
// Valid/ready channel that carries one UTF-8 byte or a status result.
// ----------------------------------------------------------------------------
interface c2u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       end_of_run;
    logic       end_of_text;

    modport source (output valid, output out_byte, output byte_valid,
                    output decode_error, output end_of_run, output end_of_text,
                    input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input decode_error, input end_of_run, input end_of_text,
                  output ready);
endinterface

/* src/c2u_regs.sv */
// ----------------------------------------------------------------------------
// c2u_regs: configuration registers
// APB-style register file holding charset and error mode.
// ----------------------------------------------------------------------------
module c2u_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [c2u_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    input  logic                       in_fire,
    output c2u_pkg::cfg_t              cfg
);
    import c2u_pkg::*;

    logic [2:0] charset_reg, charset_next;
    logic [1:0] mode_reg, mode_next;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        charset_next = charset_reg;
        mode_next    = mode_reg;
        if (wr_en && paddr[2] == REG_CHARSET)
        begin
            charset_next = pwdata[2:0];
        end
        else if (wr_en && paddr[2] == REG_MODE)
        begin
            mode_next = pwdata[1:0];
        end
        else if (in_fire && mode_reg == EM_STRICT_ALT)
        begin
            mode_next = EM_STRICT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charset_reg <= CS_UTF8;
            mode_reg    <= EM_REPLACE;
        end
        else
        begin
            charset_reg <= charset_next;
            mode_reg    <= mode_next;
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_reg} : {29'd0, charset_reg};
    assign cfg    = '{charset: charset_reg, error_mode: mode_reg};

endmodule

/* src/c2u_utf8_enc.sv */
// ----------------------------------------------------------------------------
// c2u_utf8_enc: UTF-8 byte encoder
// Gives one byte of the UTF-8 form of a code point per index, and flags
// the final byte of the sequence.
// ----------------------------------------------------------------------------
module c2u_utf8_enc (
    input  logic [20:0] cp,
    input  logic [1:0]  idx,
    output logic [7:0]  enc_byte,
    output logic        enc_last
);
    logic [1:0] len_m1;

    always_comb
    begin
        if (cp < 21'h80)
        begin
            len_m1 = 2'd0;
        end
        else if (cp < 21'h800)
        begin
            len_m1 = 2'd1;
        end
        else if (cp < 21'h10000)
        begin
            len_m1 = 2'd2;
        end
        else
        begin
            len_m1 = 2'd3;
        end
    end

    always_comb
    begin
        enc_byte = 8'h00;
        unique case (len_m1)
            2'd0: enc_byte = cp[7:0];
            2'd1: enc_byte = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2:
            begin
                unique case (idx)
                    2'd0:    enc_byte = {4'b1110, cp[15:12]};
                    2'd1:    enc_byte = {2'b10, cp[11:6]};
                    default: enc_byte = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                unique case (idx)
                    2'd0:    enc_byte = {5'b11110, cp[20:18]};
                    2'd1:    enc_byte = {2'b10, cp[17:12]};
                    2'd2:    enc_byte = {2'b10, cp[11:6]};
                    default: enc_byte = {2'b10, cp[5:0]};
                endcase
            end
        endcase
    end

    assign enc_last = (idx == len_m1);

endmodule

/* src/c2u_core.sv */
// ----------------------------------------------------------------------------
// c2u_core: decode sequencer
// Sequencer that scans UTF-8, assembles UTF-16 units, checks ASCII and handles
// bad input, driving the shared encoder one result byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module c2u_core (
    input  logic          clk,
    input  logic          rst_n,
    input  c2u_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_bv,
    output logic          out_err,
    output logic          out_eor,
    output logic          out_eot
);
    import c2u_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_RAW    = 4'd2;
    localparam logic [3:0] S_UNIT   = 4'd3;
    localparam logic [3:0] S_FRESH  = 4'd4;
    localparam logic [3:0] S_POST   = 4'd5;
    localparam logic [3:0] S_FLUSH  = 4'd6;
    localparam logic [3:0] S_ODD    = 4'd7;
    localparam logic [3:0] S_ASCII  = 4'd8;
    localparam logic [3:0] S_UNDEF  = 4'd9;
    localparam logic [3:0] S_BAD    = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_DRAIN  = 4'd13;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  ret_reg, ret_next;
    logic [7:0]  w_reg [0:3];
    logic [7:0]  w_next [0:3];
    logic [2:0]  n_reg, n_next;
    logic [7:0]  low_reg, low_next;
    logic        half_reg, half_next;
    logic [9:0]  lead_reg, lead_next;
    logic        held_reg, held_next;
    logic [1:0]  ord_reg, ord_next;
    logic        latched_reg, latched_next;
    logic        last_reg, last_next;
    logic        odd_reg, odd_next;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] u_reg, u_next;
    logic [20:0] cp_reg, cp_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stg_v_reg, stg_v_next;
    logic [7:0]  stg_byte_reg, stg_byte_next;
    logic        stg_bv_reg, stg_bv_next;
    logic        stg_err_reg, stg_err_next;
    logic        out_v_reg, out_v_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_bv_reg, out_bv_next;
    logic        out_err_reg, out_err_next;
    logic        out_eor_reg, out_eor_next;
    logic        out_eot_reg, out_eot_next;

    logic        in_fire, push_ok, push_en, drain_en;
    logic [7:0]  push_byte;
    logic        push_bv, push_err;
    logic [7:0]  enc_byte;
    logic        enc_last;
    logic [2:0]  ll, avail;
    logic        short_seq, cont_bad, u8_bad, u8_wait;
    logic [20:0] cp8;
    logic        is_bom;
    logic [1:0]  ord_new;
    logic [15:0] unit_new;
    logic        strict, u_lead, u_trail;

    c2u_utf8_enc u_enc (
        .cp       (cp_reg),
        .idx      (idx_reg),
        .enc_byte (enc_byte),
        .enc_last (enc_last)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign push_ok  = !stg_v_reg || !out_v_reg || out_ready;
    assign strict   = cfg.error_mode[1];
    assign u_lead   = (u_reg[15:10] == 6'b110110);
    assign u_trail  = (u_reg[15:10] == 6'b110111);

    // UTF-8 sequence check on the buffered bytes
    always_comb
    begin
        ll = 3'd0;
        if (!w_reg[0][7])
        begin
            ll = 3'd1;
        end
        else if (w_reg[0][7:5] == 3'b110)
        begin
            ll = 3'd2;
        end
        else if (w_reg[0][7:4] == 4'b1110)
        begin
            ll = 3'd3;
        end
        else if (w_reg[0][7:3] == 5'b11110)
        begin
            ll = 3'd4;
        end
        short_seq = (n_reg < ll);
        avail     = short_seq ? n_reg : ll;
        cont_bad  = (avail > 3'd1 && w_reg[1][7:6] != 2'b10)
                 || (avail > 3'd2 && w_reg[2][7:6] != 2'b10)
                 || (avail > 3'd3 && w_reg[3][7:6] != 2'b10);
        cp8 = {13'd0, w_reg[0]};
        if (ll == 3'd2)
        begin
            cp8 = {10'd0, w_reg[0][4:0], w_reg[1][5:0]};
        end
        else if (ll == 3'd3)
        begin
            cp8 = {5'd0, w_reg[0][3:0], w_reg[1][5:0], w_reg[2][5:0]};
        end
        else if (ll == 3'd4)
        begin
            cp8 = {w_reg[0][2:0], w_reg[1][5:0], w_reg[2][5:0], w_reg[3][5:0]};
        end
        u8_bad = (ll == 3'd0) || cont_bad || (short_seq && last_reg)
              || (!short_seq && (cp8 > 21'h10FFFF
                  || (cp8 >= 21'h0D800 && cp8 <= 21'h0DFFF)
                  || (ll > 3'd1 && cp8 < 21'h80)
                  || (ll > 3'd2 && cp8 < 21'h800)
                  || (ll > 3'd3 && cp8 < 21'h10000)));
        u8_wait = !u8_bad && short_seq;
    end

    always_comb
    begin
        is_bom  = (low_reg == 8'hFF && in_byte == 8'hFE)
               || (low_reg == 8'hFE && in_byte == 8'hFF);
        ord_new = ord_reg;
        if (ord_reg == ORD_NONE)
        begin
            ord_new = (is_bom || cfg.charset == CS_UTF16LE) ? ORD_LE : ORD_BE;
        end
        unit_new = (ord_new == ORD_LE) ? {in_byte, low_reg} : {low_reg, in_byte};
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        for (int i = 0; i < 4; i++)
        begin
            w_next[i] = w_reg[i];
        end
        n_next        = n_reg;
        low_next      = low_reg;
        half_next     = half_reg;
        lead_next     = lead_reg;
        held_next     = held_reg;
        ord_next      = ord_reg;
        latched_next  = latched_reg;
        last_next     = last_reg;
        odd_next      = odd_reg;
        byte_next     = byte_reg;
        u_next        = u_reg;
        cp_next       = cp_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        push_en       = 1'b0;
        push_byte     = 8'h00;
        push_bv       = 1'b0;
        push_err      = 1'b0;
        drain_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = in_last;
                    byte_next = in_byte;
                    odd_next  = 1'b0;
                    if (latched_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else if (cfg.charset == CS_UTF8)
                    begin
                        w_next[n_reg[1:0]] = in_byte;
                        n_next             = n_reg + 3'd1;
                        state_next         = S_SCAN;
                    end
                    else if (cfg.charset == CS_UTF16LE || cfg.charset == CS_UTF16BE)
                    begin
                        odd_next = in_last && !half_reg;
                        if (!half_reg)
                        begin
                            if (!in_last)
                            begin
                                low_next   = in_byte;
                                half_next  = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        else
                        begin
                            half_next  = 1'b0;
                            ord_next   = ord_new;
                            u_next     = unit_new;
                            state_next = S_UNIT;
                        end
                    end
                    else if (cfg.charset == CS_ASCII)
                    begin
                        state_next = S_ASCII;
                    end
                    else
                    begin
                        state_next = S_UNDEF;
                    end
                end
            end
            S_SCAN:
            begin
                if (n_reg == 3'd0 || u8_wait)
                begin
                    state_next = S_FIN;
                end
                else if (!u8_bad)
                begin
                    cnt_next   = 2'(ll - 3'd1);
                    state_next = S_RAW;
                end
                else
                begin
                    w_next[0]  = w_reg[1];
                    w_next[1]  = w_reg[2];
                    w_next[2]  = w_reg[3];
                    n_next     = n_reg - 3'd1;
                    ret_next   = S_SCAN;
                    state_next = S_BAD;
                end
            end
            S_RAW:
            begin
                if (push_ok)
                begin
                    push_en   = 1'b1;
                    push_byte = w_reg[0];
                    push_bv   = 1'b1;
                    w_next[0] = w_reg[1];
                    w_next[1] = w_reg[2];
                    w_next[2] = w_reg[3];
                    n_next    = n_reg - 3'd1;
                    cnt_next  = cnt_reg - 2'd1;
                    if (cnt_reg == 2'd0)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_UNIT:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (u_trail)
                    begin
                        cp_next    = 21'h10000 + {11'd0, lead_reg} * 21'd1024
                                   + {11'd0, u_reg[9:0]};
                        idx_next   = 2'd0;
                        ret_next   = S_POST;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ret_next   = S_FRESH;
                        state_next = S_BAD;
                    end
                end
                else
                begin
                    state_next = S_FRESH;
                end
            end
            S_FRESH:
            begin
                if (u_lead)
                begin
                    lead_next  = u_reg[9:0];
                    held_next  = 1'b1;
                    state_next = S_POST;
                end
                else if (u_trail)
                begin
                    ret_next   = S_POST;
                    state_next = S_BAD;
                end
                else
                begin
                    cp_next    = {5'd0, u_reg};
                    idx_next   = 2'd0;
                    ret_next   = S_POST;
                    state_next = S_EMIT;
                end
            end
            S_POST:
            begin
                state_next = (!last_reg || latched_reg) ? S_FIN : S_FLUSH;
            end
            S_FLUSH:
            begin
                if (held_reg)
                begin
                    held_next  = 1'b0;
                    ret_next   = S_ODD;
                    state_next = S_BAD;
                end
                else
                begin
                    state_next = S_ODD;
                end
            end
            S_ODD:
            begin
                if (odd_reg && !latched_reg)
                begin
                    ret_next   = S_FIN;
                    state_next = S_BAD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ASCII:
            begin
                if (byte_reg >= ASCII_LOW && byte_reg < ASCII_DEL)
                begin
                    if (push_ok)
                    begin
                        push_en    = 1'b1;
                        push_byte  = byte_reg;
                        push_bv    = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    ret_next   = S_FIN;
                    state_next = S_BAD;
                end
            end
            S_UNDEF:
            begin
                if (push_ok)
                begin
                    push_en      = 1'b1;
                    push_err     = 1'b1;
                    latched_next = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_BAD:
            begin
                if (strict)
                begin
                    if (push_ok)
                    begin
                        push_en      = 1'b1;
                        push_err     = 1'b1;
                        latched_next = 1'b1;
                        n_next       = 3'd0;
                        state_next   = S_FIN;
                    end
                end
                else if (cfg.error_mode == EM_REPLACE)
                begin
                    cp_next    = (cfg.charset == CS_ASCII) ? CP_QMARK : CP_REPLACE;
                    idx_next   = 2'd0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_EMIT:
            begin
                if (push_ok)
                begin
                    push_en   = 1'b1;
                    push_byte = enc_byte;
                    push_bv   = 1'b1;
                    idx_next  = idx_reg + 2'd1;
                    if (enc_last)
                    begin
                        state_next = ret_reg;
                    end
                end
            end
            S_FIN:
            begin
                if (last_reg && (!stg_v_reg || (latched_reg && !stg_err_reg)))
                begin
                    if (push_ok)
                    begin
                        push_en    = 1'b1;
                        push_err   = latched_reg;
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stg_v_reg || push_ok)
                begin
                    drain_en   = stg_v_reg;
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        n_next       = 3'd0;
                        low_next     = 8'h00;
                        half_next    = 1'b0;
                        lead_next    = 10'd0;
                        held_next    = 1'b0;
                        ord_next     = ORD_NONE;
                        latched_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result staging: the newest result waits until its end flags are known
    always_comb
    begin
        stg_v_next    = stg_v_reg;
        stg_byte_next = stg_byte_reg;
        stg_bv_next   = stg_bv_reg;
        stg_err_next  = stg_err_reg;
        out_v_next    = out_v_reg;
        out_byte_next = out_byte_reg;
        out_bv_next   = out_bv_reg;
        out_err_next  = out_err_reg;
        out_eor_next  = out_eor_reg;
        out_eot_next  = out_eot_reg;
        if (out_v_reg && out_ready)
        begin
            out_v_next = 1'b0;
        end
        if ((push_en && stg_v_reg) || drain_en)
        begin
            out_v_next    = 1'b1;
            out_byte_next = stg_byte_reg;
            out_bv_next   = stg_bv_reg;
            out_err_next  = stg_err_reg;
            out_eor_next  = drain_en;
            out_eot_next  = drain_en && last_reg;
        end
        if (push_en)
        begin
            stg_v_next    = 1'b1;
            stg_byte_next = push_byte;
            stg_bv_next   = push_bv;
            stg_err_next  = push_err;
        end
        else if (drain_en)
        begin
            stg_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            n_reg       <= 3'd0;
            half_reg    <= 1'b0;
            held_reg    <= 1'b0;
            ord_reg     <= ORD_NONE;
            latched_reg <= 1'b0;
            low_reg     <= 8'h00;
            lead_reg    <= 10'd0;
            stg_v_reg   <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            half_reg    <= half_next;
            held_reg    <= held_next;
            ord_reg     <= ord_next;
            latched_reg <= latched_next;
            low_reg     <= low_next;
            lead_reg    <= lead_next;
            stg_v_reg   <= stg_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        ret_reg      <= ret_next;
        last_reg     <= last_next;
        odd_reg      <= odd_next;
        byte_reg     <= byte_next;
        u_reg        <= u_next;
        cp_reg       <= cp_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        stg_byte_reg <= stg_byte_next;
        stg_bv_reg   <= stg_bv_next;
        stg_err_reg  <= stg_err_next;
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_err_reg  <= out_err_next;
        out_eor_reg  <= out_eor_next;
        out_eot_reg  <= out_eot_next;
    end

    assign out_valid = out_v_reg;
    assign out_byte  = out_byte_reg;
    assign out_bv    = out_bv_reg;
    assign out_err   = out_err_reg;
    assign out_eor   = out_eor_reg;
    assign out_eot   = out_eot_reg;

endmodule

/* src/charset_to_utf8_decoder.sv */
// Each result is staged until the next one is pushed or its input byte is finished;
// a new input byte is taken only once the last one is fully processed.
// Reset: asynchronous, active low; loads charset UTF-8 and error mode replace.
// ----------------------------------------------------------------------------
// charset_to_utf8_decoder: top level
// Transcodes UTF-8, UTF-16 LE/BE or ASCII byte strings to checked UTF-8.
// ----------------------------------------------------------------------------
module charset_to_utf8_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    c2u_in_if.sink                     byte_in,
    c2u_out_if.source                  utf8_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [c2u_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import c2u_pkg::*;

    cfg_t cfg;
    logic in_ready;
    logic in_fire;

    assign pready        = 1'b1;
    assign byte_in.ready = in_ready;
    assign in_fire       = byte_in.valid && in_ready;

    c2u_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .in_fire (in_fire),
        .cfg     (cfg)
    );

    c2u_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (byte_in.valid),
        .in_ready  (in_ready),
        .in_byte   (byte_in.data_byte),
        .in_last   (byte_in.last_byte),
        .out_valid (utf8_out.valid),
        .out_ready (utf8_out.ready),
        .out_byte  (utf8_out.out_byte),
        .out_bv    (utf8_out.byte_valid),
        .out_err   (utf8_out.decode_error),
        .out_eor   (utf8_out.end_of_run),
        .out_eot   (utf8_out.end_of_text)
    );

endmodule

/* src/c2u_checker.sv */
// ----------------------------------------------------------------------------
// c2u_checker: port checks
// Checks on the decoder ports over time, bound to the top level.
// ----------------------------------------------------------------------------
module c2u_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       decode_error,
    input logic       end_of_run,
    input logic       end_of_text
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(end_of_run) && $stable(end_of_text))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00)
        else $error("status result with nonzero byte");

    a_eot_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> end_of_run)
        else $error("end of text without end of run");

    a_err_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decode_error |-> !byte_valid)
        else $error("error result carries data");

endmodule

bind charset_to_utf8_decoder c2u_checker u_c2u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_in.valid),
    .in_ready     (byte_in.ready),
    .out_valid    (utf8_out.valid),
    .out_ready    (utf8_out.ready),
    .out_byte     (utf8_out.out_byte),
    .byte_valid   (utf8_out.byte_valid),
    .decode_error (utf8_out.decode_error),
    .end_of_run   (utf8_out.end_of_run),
    .end_of_text  (utf8_out.end_of_text)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: charset-to-UTF-8 decoder testbench
// Sends byte strings in every charset and error mode through the decoder,
// with random gaps and stalls on both channels. A scoreboard predicts each
// UTF-8 byte and status result and checks every output transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
    import c2u_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PER_BYTE = 16;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       end_of_run;
        logic       end_of_text;
    } utf8_res_t;

    class utf8_scoreboard;
        logic [2:0] charset;
        logic [1:0] error_mode;
        logic [7:0] pend_bytes[3];
        int         pend_cnt;
        logic [7:0] low_half;
        bit         half_held;
        logic [15:0] lead_unit;
        bit         lead_held;
        logic [1:0] order;
        bit         err_latched;
        utf8_res_t  step_res[$];
        utf8_res_t  expected[$];
        int         errors;

        function void clear_string();
            pend_cnt = 0;
            low_half = 0;
            half_held = 0;
            lead_unit = 0;
            lead_held = 0;
            order = ORD_NONE;
            err_latched = 0;
        endfunction

        function void reset_all();
            charset = CS_UTF8;
            error_mode = EM_REPLACE;
            clear_string();
            expected.delete();
            errors = 0;
        endfunction

        function void add(logic [7:0] b, bit v, bit e);
            utf8_res_t r;
            if (step_res.size() >= MAX_PER_BYTE)
                return;
            r = '0;
            r.out_byte = b;
            r.byte_valid = v;
            r.decode_error = e;
            step_res.push_back(r);
        endfunction

        function void encode_cp(int unsigned cp);
            if (cp < 'h80)
                add(cp[7:0], 1, 0);
            else if (cp < 'h800)
            begin
                add(8'hC0 | cp[10:6], 1, 0);
                add(8'h80 | cp[5:0], 1, 0);
            end
            else if (cp < 'h10000)
            begin
                add(8'hE0 | cp[15:12], 1, 0);
                add(8'h80 | cp[11:6], 1, 0);
                add(8'h80 | cp[5:0], 1, 0);
            end
            else
            begin
                add(8'hF0 | cp[20:18], 1, 0);
                add(8'h80 | cp[17:12], 1, 0);
                add(8'h80 | cp[11:6], 1, 0);
                add(8'h80 | cp[5:0], 1, 0);
            end
        endfunction

        function bit handle_bad();
            if (error_mode == EM_IGNORE)
                return 0;
            if (error_mode == EM_REPLACE)
            begin
                if (charset == CS_ASCII)
                    add(CP_QMARK[7:0], 1, 0);
                else
                    encode_cp(CP_REPLACE);
                return 0;
            end
            if (!err_latched)
            begin
                add(8'h00, 0, 1);
                err_latched = 1;
            end
            return 1;
        endfunction

        function int seq_len(logic [7:0] b);
            if (b < 8'h80) return 1;
            if (b[7:5] == 3'b110) return 2;
            if (b[7:4] == 4'b1110) return 3;
            if (b[7:3] == 5'b11110) return 4;
            return 0;
        endfunction

        function void utf8_byte(logic [7:0] b, bit last);
            logic [7:0] w[4];
            int n;
            int len;
            int avail;
            int st;
            int drop;
            int unsigned cp;
            n = pend_cnt;
            for (int i = 0; i < n; i++)
                w[i] = pend_bytes[i];
            w[n] = b;
            n++;
            while (n > 0)
            begin
                len = seq_len(w[0]);
                st = 1;
                if (len == 0)
                    st = 2;
                else
                begin
                    avail = (n < len) ? n : len;
                    for (int i = 1; i < avail; i++)
                        if (w[i][7:6] != 2'b10)
                            st = 2;
                    if (st != 2 && n < len)
                        st = last ? 2 : 0;
                    if (st == 1)
                    begin
                        case (len)
                            1: cp = w[0];
                            2: cp = {w[0][4:0], w[1][5:0]};
                            3: cp = {w[0][3:0], w[1][5:0], w[2][5:0]};
                            default: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
                        endcase
                        if (cp > 'h10FFFF || (cp >= 'hD800 && cp <= 'hDFFF))
                            st = 2;
                        else if ((len > 1 && cp < 'h80) || (len > 2 && cp < 'h800)
                                 || (len > 3 && cp < 'h10000))
                            st = 2;
                    end
                end
                if (st == 0)
                    break;
                drop = 1;
                if (st == 1)
                begin
                    for (int i = 0; i < len; i++)
                        add(w[i], 1, 0);
                    drop = len;
                end
                else if (handle_bad())
                begin
                    n = 0;
                    break;
                end
                for (int i = 0; i + drop < n; i++)
                    w[i] = w[i + drop];
                n -= drop;
            end
            if (n > 3)
                n = 3;
            for (int i = 0; i < n; i++)
                pend_bytes[i] = w[i];
            pend_cnt = n;
        endfunction

        function void utf16_unit(logic [15:0] u);
            if (lead_held)
            begin
                lead_held = 0;
                if (u >= 16'hDC00 && u <= 16'hDFFF)
                begin
                    encode_cp(32'h10000 + ((32'(lead_unit) - 32'hD800) << 10)
                              + (32'(u) - 32'hDC00));
                    return;
                end
                if (handle_bad())
                    return;
            end
            if (u >= 16'hD800 && u <= 16'hDBFF)
            begin
                lead_unit = u;
                lead_held = 1;
            end
            else if (u >= 16'hDC00 && u <= 16'hDFFF)
                void'(handle_bad());
            else
                encode_cp(u);
        endfunction

        function void utf16_byte(logic [7:0] b, bit last);
            logic [7:0] b0;
            if (!half_held)
            begin
                if (!last)
                begin
                    low_half = b;
                    half_held = 1;
                    return;
                end
            end
            else
            begin
                b0 = low_half;
                half_held = 0;
                if (order == ORD_NONE)
                begin
                    if ((b0 == 8'hFF && b == 8'hFE) || (b0 == 8'hFE && b == 8'hFF))
                        order = ORD_LE;
                    else
                        order = (charset == CS_UTF16LE) ? ORD_LE : ORD_BE;
                end
                utf16_unit((order == ORD_LE) ? {b, b0} : {b0, b});
                if (!last || err_latched)
                    return;
            end
            if (lead_held)
            begin
                lead_held = 0;
                void'(handle_bad());
            end
        endfunction

        function void note_input(logic [7:0] b, bit last);
            bit odd;
            if (error_mode == EM_STRICT_ALT)
                error_mode = EM_STRICT;
            step_res.delete();
            if (!err_latched)
            begin
                if (charset == CS_UTF8)
                    utf8_byte(b, last);
                else if (charset == CS_UTF16LE || charset == CS_UTF16BE)
                begin
                    odd = last && !half_held;
                    utf16_byte(b, last);
                    if (odd && !err_latched)
                        void'(handle_bad());
                end
                else if (charset == CS_ASCII)
                begin
                    if (b >= ASCII_LOW && b < ASCII_DEL)
                        add(b, 1, 0);
                    else
                        void'(handle_bad());
                end
                else
                begin
                    add(8'h00, 0, 1);
                    err_latched = 1;
                end
            end
            if (last)
            begin
                if (step_res.size() == 0
                    || (err_latched && !step_res[step_res.size() - 1].decode_error))
                    add(8'h00, 0, err_latched);
                step_res[step_res.size() - 1].end_of_text = 1;
                clear_string();
            end
            if (step_res.size() > 0)
                step_res[step_res.size() - 1].end_of_run = 1;
            foreach (step_res[i])
                expected.push_back(step_res[i]);
        endfunction

        function void report_mismatch(string what, utf8_res_t got, utf8_res_t exp_r);
            $display("MISMATCH %s: got %h/%b%b%b%b exp %h/%b%b%b%b", what,
                     got.out_byte, got.byte_valid, got.decode_error, got.end_of_run,
                     got.end_of_text, exp_r.out_byte, exp_r.byte_valid,
                     exp_r.decode_error, exp_r.end_of_run, exp_r.end_of_text);
            errors++;
        endfunction

        function void check_result(utf8_res_t got);
            utf8_res_t exp_r;
            if (expected.size() == 0)
            begin
                report_mismatch("unexpected transfer", got, '0);
                return;
            end
            exp_r = expected.pop_front();
            if (got.out_byte !== exp_r.out_byte)
                report_mismatch("out_byte", got, exp_r);
            if (got.byte_valid !== exp_r.byte_valid)
                report_mismatch("byte_valid", got, exp_r);
            if (got.decode_error !== exp_r.decode_error)
                report_mismatch("decode_error", got, exp_r);
            if (got.end_of_run !== exp_r.end_of_run)
                report_mismatch("end_of_run", got, exp_r);
            if (got.end_of_text !== exp_r.end_of_text)
                report_mismatch("end_of_text", got, exp_r);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    c2u_in_if  byte_in ();
    c2u_out_if utf8_out ();

    charset_to_utf8_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in.sink),
        .utf8_out (utf8_out.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    utf8_scoreboard sb;
    bit  hold_req;
    bit  no_idle;
    int  cycles;
    int  sent_random;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        utf8_res_t r;
        if (rst_n && byte_in.valid && byte_in.ready)
            sb.note_input(byte_in.data_byte, byte_in.last_byte);
        if (rst_n && utf8_out.valid && utf8_out.ready)
        begin
            r.out_byte = utf8_out.out_byte;
            r.byte_valid = utf8_out.byte_valid;
            r.decode_error = utf8_out.decode_error;
            r.end_of_run = utf8_out.end_of_run;
            r.end_of_text = utf8_out.end_of_text;
            sb.check_result(r);
        end
    end

    initial
    begin
        int stall;
        utf8_out.ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                @(negedge clk);
                utf8_out.ready <= 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                utf8_out.ready <= 1;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 8);
                if (stall > 0)
                begin
                    @(negedge clk);
                    utf8_out.ready <= 0;
                    repeat (stall - 1) @(negedge clk);
                end
                @(negedge clk);
                utf8_out.ready <= 1;
            end
            do @(posedge clk); while (!utf8_out.valid);
        end
    end

    task automatic send_byte(logic [7:0] b, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            byte_in.valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_in.valid <= 1;
        byte_in.data_byte <= b;
        byte_in.last_byte <= last;
        do @(posedge clk); while (!byte_in.ready);
    endtask

    task automatic send_string(logic [7:0] s[$]);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        byte_in.valid <= 0;
        while (sb.expected.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        if (addr == {REG_CHARSET, 2'b00})
            sb.charset = value[2:0];
        else
            sb.error_mode = value[1:0];
        @(negedge clk);
        psel <= 0;
        penable <= 0;
    endtask

    task automatic set_mode(logic [2:0] cs, logic [1:0] em);
        drain();
        reg_write({REG_CHARSET, 2'b00}, 32'(cs));
        reg_write({REG_MODE, 2'b00}, 32'(em));
    endtask

    function automatic void put_cp(ref logic [7:0] s[$], input int unsigned cp,
                                   input logic [2:0] cs);
        int unsigned v;
        logic [15:0] u[$];
        if (cs == CS_UTF8)
        begin
            if (cp < 'h80)
                s.push_back(cp[7:0]);
            else if (cp < 'h800)
            begin
                s.push_back(8'hC0 | cp[10:6]);
                s.push_back(8'h80 | cp[5:0]);
            end
            else if (cp < 'h10000)
            begin
                s.push_back(8'hE0 | cp[15:12]);
                s.push_back(8'h80 | cp[11:6]);
                s.push_back(8'h80 | cp[5:0]);
            end
            else
            begin
                s.push_back(8'hF0 | cp[20:18]);
                s.push_back(8'h80 | cp[17:12]);
                s.push_back(8'h80 | cp[11:6]);
                s.push_back(8'h80 | cp[5:0]);
            end
        end
        else
        begin
            if (cp >= 'h10000)
            begin
                v = cp - 'h10000;
                u.push_back(16'hD800 + v[19:10]);
                u.push_back(16'hDC00 + v[9:0]);
            end
            else
                u.push_back(cp[15:0]);
            foreach (u[i])
                if (cs == CS_UTF16LE)
                begin
                    s.push_back(u[i][7:0]);
                    s.push_back(u[i][15:8]);
                end
                else
                begin
                    s.push_back(u[i][15:8]);
                    s.push_back(u[i][7:0]);
                end
        end
    endfunction

    function automatic int unsigned rand_cp();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 'h7F);
            1: return $urandom_range('h80, 'h7FF);
            2: return $urandom_range('h800, 'hD7FF);
            3: return $urandom_range('hE000, 'hFFFF);
            default: return $urandom_range('h10000, 'h10FFFF);
        endcase
    endfunction

    task automatic random_string(logic [2:0] cs);
        logic [7:0] s[$];
        int len;
        len = $urandom_range(1, 5);
        if (cs != CS_UTF8 && cs <= CS_UTF16BE && $urandom_range(0, 3) == 0)
        begin
            s.push_back($urandom_range(0, 1) ? 8'hFF : 8'hFE);
            s.push_back(s[0] ^ 8'h01);
        end
        for (int i = 0; i < len; i++)
        begin
            if (cs == CS_ASCII)
                s.push_back($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(32, 126));
            else if ($urandom_range(0, 5) == 0)
                s.push_back($urandom_range(0, 255));
            else if (cs != CS_UTF8 && $urandom_range(0, 9) == 0)
                put_cp(s, $urandom_range('hD800, 'hDFFF), cs);
            else
                put_cp(s, rand_cp(), cs);
        end
        if ($urandom_range(0, 6) == 0)
            void'(s.pop_back());
        if (s.size() == 0)
            s.push_back($urandom_range(0, 255));
        sent_random += s.size();
        send_string(s);
    endtask

    initial
    begin
        logic [2:0] cs_list[12] = '{CS_UTF8, CS_UTF8, CS_UTF8, CS_UTF16LE, CS_UTF16BE,
                                    CS_UTF16BE, CS_ASCII, CS_ASCII, CS_ASCII, 3'd4,
                                    3'd7, CS_UTF16LE};
        logic [1:0] em_list[12] = '{EM_REPLACE, EM_IGNORE, EM_STRICT, EM_REPLACE,
                                    EM_IGNORE, EM_STRICT, EM_REPLACE, EM_IGNORE,
                                    EM_STRICT_ALT, EM_REPLACE, EM_IGNORE, EM_STRICT_ALT};
        int phase;
        sb = new();
        sb.reset_all();
        cycles = 0;
        sent_random = 0;
        hold_req = 0;
        no_idle = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        byte_in.valid = 0;
        byte_in.data_byte = 0;
        byte_in.last_byte = 0;
        @(posedge rst_n);

        send_string('{8'h41, 8'hC3, 8'hA9, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
        send_string('{8'hE2, 8'h41, 8'hC0, 8'hAF, 8'hED, 8'hA0, 8'h80, 8'hF8});
        send_string('{8'hF0, 8'h9F, 8'h98});
        send_string('{8'h00});
        set_mode(CS_UTF8, EM_STRICT);
        send_string('{8'h80, 8'h41, 8'hFF});
        set_mode(CS_UTF16LE, EM_REPLACE);
        send_string('{8'hFE, 8'hFF, 8'h00, 8'hD8, 8'h41, 8'h00, 8'h00, 8'hDC, 8'h3D, 8'hD8});
        set_mode(CS_UTF16BE, EM_REPLACE);
        send_string('{8'hD8, 8'h3D, 8'hDE, 8'h00, 8'hFF});
        set_mode(CS_ASCII, EM_REPLACE);
        send_string('{8'h20, 8'h7E, 8'h7F, 8'h1F});

        phase = 0;
        while (sent_random < 330)
        begin
            set_mode(cs_list[phase % 12], em_list[phase % 12]);
            no_idle = (phase % 5 == 4);
            if (phase == 2)
                hold_req = 1;
            for (int k = 0; k < 8; k++)
                random_string(cs_list[phase % 12]);
            phase++;
        end
        no_idle = 0;

        drain();
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
src/c2u_pkg.sv
src/c2u_in_if.sv
src/c2u_out_if.sv
src/c2u_regs.sv
src/c2u_utf8_enc.sv
src/c2u_core.sv
src/charset_to_utf8_decoder.sv
src/c2u_checker.sv
dv/tb_top.sv
